@@ rtl/core/assert_macros.svh @@
// Assertion macros used by the top-level RTL file of the option scanner.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must never hold while out of reset
`define ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("assertion failed");

// a implies b in the same cycle
`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("assertion failed");

// a implies b in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("assertion failed");

`endif

@@ rtl/core/hbh_pkg.sv @@
// Types and constants of the hop-by-hop router alert scanner.
`default_nettype none

package hbh_pkg;

	// option codes and limits
	localparam logic [7:0] OPT_PAD1         = 8'd0;
	localparam logic [7:0] OPT_ROUTER_ALERT = 8'd5;
	localparam logic [7:0] ALERT_OPT_LEN    = 8'd2;
	localparam logic [2:0] MIN_AREA_BYTES   = 3'd6;

	// parser phase
	typedef enum logic [1:0] {
		PH_TYPE,
		PH_LEN,
		PH_SKIP,
		PH_DONE
	} hbh_phase_t;

	// one input word held in the input register
	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} hbh_word_t;

	// flags reported at the end of an options area
	typedef struct packed {
		logic alert_found;
		logic truncated;
		logic area_too_short;
	} hbh_result_t;

endpackage

`default_nettype wire

@@ rtl/core/hbh_in_stage.sv @@
// Input register stage: takes one option byte word per cycle while in_ready is high.
`default_nettype none

module hbh_in_stage (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [7:0]        option_byte,
	input  wire logic              last_byte,
	input  wire logic              advance,
	output logic                   valid_s1,
	output hbh_pkg::hbh_word_t     word_s1
);
	import hbh_pkg::*;

	logic load;

	// stage is free when empty or being drained this cycle
	assign in_ready = !valid_s1 || advance;
	assign load     = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// payload, no reset needed
	always_ff @(posedge clk) begin
		if (load) begin
			word_s1.data <= option_byte;
			word_s1.last <= last_byte;
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/hbh_parser.sv @@
// TLV walk over the options area: parser state and end-of-area flags.
`default_nettype none

module hbh_parser (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                advance,
	input  wire hbh_pkg::hbh_word_t  word_s1,
	output logic                     result_load,
	output hbh_pkg::hbh_result_t     result
);
	import hbh_pkg::*;

	hbh_phase_t phase_q, phase_d;
	logic [7:0] left_q, left_d;
	logic       is_alert_q, is_alert_d;
	logic       len_ok_q, len_ok_d;
	logic       first_zero_q, first_zero_d;
	logic       seen_alert_q, seen_alert_d;
	logic [2:0] count_q, count_d;
	logic       alert_hit;
	logic       short_area;
	logic       end_open;

	// second alert data byte closes a valid MLD alert
	assign alert_hit = is_alert_q && len_ok_q && (left_q == 8'd1) && first_zero_q
		&& (word_s1.data == 8'd0);

	// next phase
	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			PH_TYPE: begin
				if (word_s1.data != OPT_PAD1) phase_d = PH_LEN;
			end
			PH_LEN: begin
				phase_d = (word_s1.data == 8'd0) ? PH_TYPE : PH_SKIP;
			end
			PH_SKIP: begin
				if (alert_hit) phase_d = PH_DONE;
				else if (left_q <= 8'd1) phase_d = PH_TYPE;
			end
			PH_DONE: begin
				phase_d = PH_DONE;
			end
			default: phase_d = PH_DONE;
		endcase
	end

	// option bookkeeping and flags
	always_comb begin
		left_d       = left_q;
		is_alert_d   = is_alert_q;
		len_ok_d     = len_ok_q;
		first_zero_d = first_zero_q;
		seen_alert_d = seen_alert_q;
		count_d      = (count_q < MIN_AREA_BYTES) ? count_q + 3'd1 : count_q;
		unique case (phase_q)
			PH_TYPE: begin
				if (word_s1.data != OPT_PAD1) is_alert_d = (word_s1.data == OPT_ROUTER_ALERT);
			end
			PH_LEN: begin
				left_d       = word_s1.data;
				len_ok_d     = (word_s1.data == ALERT_OPT_LEN);
				first_zero_d = 1'b0;
			end
			PH_SKIP: begin
				if (is_alert_q && len_ok_q && (left_q == 8'd2))
					first_zero_d = (word_s1.data == 8'd0);
				if (alert_hit) seen_alert_d = 1'b1;
				if (left_q != 8'd0) left_d = left_q - 8'd1;
			end
			default: begin
			end
		endcase
	end

	// report on the last byte
	assign short_area  = count_d < MIN_AREA_BYTES;
	assign end_open    = (phase_d == PH_LEN) || (phase_d == PH_SKIP);
	assign result_load = advance && word_s1.last;

	always_comb begin
		result.alert_found    = seen_alert_d && !short_area;
		result.truncated      = end_open && !short_area;
		result.area_too_short = short_area;
	end

	// state update; the last byte returns everything to reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_TYPE;
			left_q       <= 8'd0;
			is_alert_q   <= 1'b0;
			len_ok_q     <= 1'b0;
			first_zero_q <= 1'b0;
			seen_alert_q <= 1'b0;
			count_q      <= 3'd0;
		end else if (advance) begin
			if (word_s1.last) begin
				phase_q      <= PH_TYPE;
				left_q       <= 8'd0;
				is_alert_q   <= 1'b0;
				len_ok_q     <= 1'b0;
				first_zero_q <= 1'b0;
				seen_alert_q <= 1'b0;
				count_q      <= 3'd0;
			end else begin
				phase_q      <= phase_d;
				left_q       <= left_d;
				is_alert_q   <= is_alert_d;
				len_ok_q     <= len_ok_d;
				first_zero_q <= first_zero_d;
				seen_alert_q <= seen_alert_d;
				count_q      <= count_d;
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/hop_by_hop_router_alert_scan.sv @@
// IPv6 hop-by-hop option scanner for MLD router alerts.
// Input channel: one option byte per word (option_byte, last_byte), starting
// after the two-byte extension header, last_byte marking the end of the area.
// Output channel: one word per area (alert_found, truncated, area_too_short),
// produced for the word carrying last_byte and for no other.
// Throughput: one input word per cycle while in_ready is high. Each byte is
// registered, then walks the option state combinationally; the result is held
// in an output register, so a last byte passes the input register and then
// the output register before its result shows on out_valid.
// When the receiver stalls, the result register holds and the input register
// keeps taking bytes that produce no result; a last byte waits in the input
// register until the output register frees, and in_ready drops behind it.
// Reset clears the parser to the start of a new area and empties both registers.
// After each last byte the parser returns to its reset state by itself.
`default_nettype none

`include "assert_macros.svh"

module hop_by_hop_router_alert_scan (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] option_byte,
	input  wire logic       last_byte,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic            alert_found,
	output logic            truncated,
	output logic            area_too_short
);
	import hbh_pkg::*;

	logic        valid_s1;
	hbh_word_t   word_s1;
	logic        out_free;
	logic        advance;
	logic        result_load;
	hbh_result_t result;
	hbh_result_t result_q;

	// a byte moves on unless it is a last byte facing a full result register
	assign out_free = !out_valid || out_ready;
	assign advance  = valid_s1 && (!word_s1.last || out_free);

	hbh_in_stage u_in (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.option_byte (option_byte),
		.last_byte   (last_byte),
		.advance     (advance),
		.valid_s1    (valid_s1),
		.word_s1     (word_s1)
	);

	hbh_parser u_parse (
		.clk         (clk),
		.arst_n      (arst_n),
		.advance     (advance),
		.word_s1     (word_s1),
		.result_load (result_load),
		.result      (result)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (result_load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (result_load) result_q <= result;
	end

	assign alert_found    = result_q.alert_found;
	assign truncated      = result_q.truncated;
	assign area_too_short = result_q.area_too_short;

	// checks
	`ASSERT_NEVER(a_short_no_alert, clk, arst_n, out_valid && alert_found && area_too_short)
	`ASSERT_NEVER(a_short_no_trunc, clk, arst_n, out_valid && truncated && area_too_short)
	`ASSERT_IMPLIES(a_stall_has_word, clk, arst_n, !in_ready, valid_s1 && word_s1.last)
	`ASSERT_NEXT(a_drain_empties, clk, arst_n, out_valid && out_ready && !result_load, !out_valid)

endmodule

`default_nettype wire

@@ test/testbench.sv @@
// Testbench for the hop-by-hop router alert scanner: directed and random areas.
`timescale 1ns / 1ps

module testbench;
	import hbh_pkg::*;

	localparam int RANDOM_WORDS = 1550;
	localparam int CYCLE_LIMIT  = 100000;
	localparam int DRAIN_CYCLES = 8;

	// flags of one area as they appear on the ports
	localparam hbh_result_t RES_NONE  = 3'b000;
	localparam hbh_result_t RES_SHORT = 3'b001;
	localparam hbh_result_t RES_TRUNC = 3'b010;
	localparam hbh_result_t RES_ALERT = 3'b100;

	typedef struct packed {
		logic [7:0]  data;
		logic        last;
		logic        typed;
		hbh_result_t want;
	} stim_row_t;

	// directed areas; typed flags on the last word of each
	localparam stim_row_t DIRECTED [24] = '{
		// lone Pad1: short area
		{8'h00, 1'b1, 1'b1, RES_SHORT},
		// complete MLD alert inside a short area stays hidden
		{8'h05, 1'b0, 1'b0, RES_NONE},
		{8'h02, 1'b0, 1'b0, RES_NONE},
		{8'h00, 1'b0, 1'b0, RES_NONE},
		{8'h00, 1'b1, 1'b1, RES_SHORT},
		// MLD alert, words after the stop are ignored
		{8'h05, 1'b0, 1'b0, RES_NONE},
		{8'h02, 1'b0, 1'b0, RES_NONE},
		{8'h00, 1'b0, 1'b0, RES_NONE},
		{8'h00, 1'b0, 1'b0, RES_NONE},
		{8'h00, 1'b0, 1'b0, RES_NONE},
		{8'h00, 1'b1, 1'b1, RES_ALERT},
		// type byte with no length byte after it
		{8'h00, 1'b0, 1'b0, RES_NONE},
		{8'h00, 1'b0, 1'b0, RES_NONE},
		{8'h00, 1'b0, 1'b0, RES_NONE},
		{8'h00, 1'b0, 1'b0, RES_NONE},
		{8'h00, 1'b0, 1'b0, RES_NONE},
		{8'hFF, 1'b1, 1'b1, RES_TRUNC},
		// alert carrying value 1 is skipped, then an option runs off the end
		{8'h05, 1'b0, 1'b0, RES_NONE},
		{8'h02, 1'b0, 1'b0, RES_NONE},
		{8'h00, 1'b0, 1'b0, RES_NONE},
		{8'h01, 1'b0, 1'b0, RES_NONE},
		{8'h05, 1'b0, 1'b0, RES_NONE},
		{8'hFF, 1'b0, 1'b0, RES_NONE},
		{8'h00, 1'b1, 1'b1, RES_TRUNC}
	};

	logic       clk = 1'b0;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [7:0] option_byte;
	logic       last_byte;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic       alert_found;
	logic       truncated;
	logic       area_too_short;

	int          cycle_count = 0;
	int          mismatches = 0;
	hbh_result_t flags_due [$];
	hbh_result_t seen_flags;
	hbh_result_t due_flags;
	logic [7:0]  area_q [$];

	// scanner state mirrored by the predictor
	hbh_phase_t phase;
	logic [7:0] opt_left;
	logic       opt_is_alert;
	logic       alert_len_ok;
	logic       first_val_zero;
	logic       got_alert;
	logic       got_trunc;
	logic [2:0] area_bytes;

	// no idling on either side inside this window
	wire steady = cycle_count >= 600 && cycle_count < 1400;

	hop_by_hop_router_alert_scan dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.option_byte(option_byte),
		.last_byte(last_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.alert_found(alert_found),
		.truncated(truncated),
		.area_too_short(area_too_short)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic void clear_scan();
		phase          = PH_TYPE;
		opt_left       = 8'd0;
		opt_is_alert   = 1'b0;
		alert_len_ok   = 1'b0;
		first_val_zero = 1'b0;
		got_alert      = 1'b0;
		got_trunc      = 1'b0;
		area_bytes     = 3'd0;
	endfunction

	// advance the option walk by one word; returns 1 when the word closes an area
	function automatic logic scan_word(input logic [7:0] b, input logic l,
			output hbh_result_t flags);
		logic short_area;
		flags = RES_NONE;
		if (area_bytes < MIN_AREA_BYTES)
			area_bytes++;
		case (phase)
		PH_TYPE: if (b != OPT_PAD1) begin
			opt_is_alert = (b == OPT_ROUTER_ALERT);
			phase = PH_LEN;
		end
		PH_LEN: begin
			opt_left       = b;
			alert_len_ok   = (b == ALERT_OPT_LEN);
			first_val_zero = 1'b0;
			phase          = (b == 8'd0) ? PH_TYPE : PH_SKIP;
		end
		PH_SKIP: begin
			// MLD alert: both value bytes zero
			if (opt_is_alert && alert_len_ok) begin
				if (opt_left == ALERT_OPT_LEN) begin
					first_val_zero = (b == 8'd0);
				end else if (opt_left == 8'd1 && first_val_zero && b == 8'd0) begin
					got_alert = 1'b1;
					phase     = PH_DONE;
				end
			end
			if (opt_left != 8'd0)
				opt_left--;
			if (phase == PH_SKIP && opt_left == 8'd0)
				phase = PH_TYPE;
		end
		default: phase = PH_DONE;
		endcase
		if (!l)
			return 1'b0;
		if (phase == PH_LEN || phase == PH_SKIP)
			got_trunc = 1'b1;
		short_area = area_bytes < MIN_AREA_BYTES;
		flags.alert_found    = got_alert && !short_area;
		flags.truncated      = got_trunc && !short_area;
		flags.area_too_short = short_area;
		clear_scan();
		return 1'b1;
	endfunction

	// random area: mostly well-formed options, some cut short, some noise
	function automatic void build_area();
		int kind;
		int len;
		area_q.delete();
		kind = $urandom_range(0, 99);
		if (kind < 75) begin
			repeat ($urandom_range(1, 5)) begin
				case ($urandom_range(0, 4))
				0: area_q.push_back(OPT_PAD1);
				1, 2: begin
					// router alert of length 2, value mostly zero
					area_q.push_back(OPT_ROUTER_ALERT);
					area_q.push_back(ALERT_OPT_LEN);
					repeat (2)
						area_q.push_back($urandom_range(0, 3) == 0 ?
							8'($urandom_range(0, 255)) : 8'd0);
				end
				default: begin
					area_q.push_back($urandom_range(0, 3) == 0 ?
						OPT_ROUTER_ALERT : 8'($urandom_range(1, 255)));
					len = $urandom_range(0, 63) == 0 ? $urandom_range(7, 255) :
						$urandom_range(0, 6);
					area_q.push_back(8'(len));
					repeat (len)
						area_q.push_back(8'($urandom_range(0, 255)));
				end
				endcase
			end
			// leading padding so most areas reach the minimum size
			if ($urandom_range(0, 9) < 7)
				while (area_q.size() < MIN_AREA_BYTES)
					area_q.push_front(OPT_PAD1);
			// broken areas lose their tail
			if (kind >= 60 && area_q.size() > 1)
				repeat ($urandom_range(1, area_q.size() > 3 ? 3 : area_q.size() - 1))
					void'(area_q.pop_back());
		end else begin
			len = kind < 90 ? $urandom_range(1, 12) : $urandom_range(1, 5);
			repeat (len)
				case ($urandom_range(0, 3))
				0: area_q.push_back(OPT_PAD1);
				1: area_q.push_back(OPT_ROUTER_ALERT);
				2: area_q.push_back(ALERT_OPT_LEN);
				default: area_q.push_back(8'($urandom_range(0, 255)));
				endcase
		end
	endfunction

	// present one word at the falling edge, hold until taken
	task automatic send_word(input logic [7:0] b, input logic l, input logic typed,
			input hbh_result_t want);
		hbh_result_t flags;
		while (!steady && $urandom_range(0, 99) < 16) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid    <= 1'b1;
		option_byte <= b;
		last_byte   <= l;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		if (scan_word(b, l, flags))
			flags_due.push_back(typed ? want : flags);
		@(negedge clk);
	endtask

	// sender stops until every pending area has reported
	task automatic hold_until_drained();
		in_valid <= 1'b0;
		@(negedge clk);
		while (flags_due.size() != 0)
			@(negedge clk);
	endtask

	// receiver stalls at random
	always @(negedge clk)
		out_ready <= steady || $urandom_range(0, 99) >= 16;

	// compare each result word with the oldest pending area
	always @(posedge clk) begin : flag_check
		if (out_valid && out_ready) begin
			seen_flags = {alert_found, truncated, area_too_short};
			if (flags_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result word: alert %0b trunc %0b short %0b",
						seen_flags.alert_found, seen_flags.truncated,
						seen_flags.area_too_short);
			end else begin
				due_flags = flags_due.pop_front();
				if (seen_flags.alert_found !== due_flags.alert_found ||
						seen_flags.truncated !== due_flags.truncated ||
						seen_flags.area_too_short !== due_flags.area_too_short) begin
					mismatches++;
					if (mismatches <= 10)
						$display("flag mismatch: expected alert %0b trunc %0b short %0b,",
							due_flags.alert_found, due_flags.truncated,
							due_flags.area_too_short,
							" got alert %0b trunc %0b short %0b",
							seen_flags.alert_found, seen_flags.truncated,
							seen_flags.area_too_short);
				end
			end
		end
	end

	// cycle limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin : stimulus
		int n_sent;
		int n_areas;
		n_sent      = 0;
		n_areas     = 0;
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		option_byte = 8'd0;
		last_byte   = 1'b0;
		clear_scan();
		repeat (7)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int i = 0; i < 24; i++)
			send_word(DIRECTED[i].data, DIRECTED[i].last, DIRECTED[i].typed,
				DIRECTED[i].want);
		hold_until_drained();

		while (n_sent < RANDOM_WORDS) begin
			build_area();
			for (int i = 0; i < area_q.size(); i++)
				send_word(area_q[i], i == area_q.size() - 1, 1'b0, RES_NONE);
			n_sent += area_q.size();
			n_areas++;
			if (n_areas == 40)
				hold_until_drained();
		end

		hold_until_drained();
		repeat (DRAIN_CYCLES)
			@(posedge clk);
		if (mismatches == 0 && flags_due.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
